### hdl/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;

	localparam int OPW       = 32;
	localparam int EXP_BITS  = 32;
	localparam int CNT_W     = $clog2(OPW + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

	localparam logic [OPW-1:0] MODULUS_RESET  = 32'h694d_12c5;
	localparam logic [OPW-1:0] EXPONENT_RESET = 32'd17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start_acc;
		logic start_sq;
		logic in_ready;
		logic out_load;
	} ctrl_t;

endpackage

### hdl/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: p = a * b mod m, one bit of a per cycle.
module mexp_mulmod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [mexp_pkg::OPW-1:0] a,
	input  logic [mexp_pkg::OPW-1:0] b,
	input  logic [mexp_pkg::OPW:0]   m,     // zero modulus arrives as 2^OPW
	output logic                    done,
	output logic [mexp_pkg::OPW-1:0] p
);
	import mexp_pkg::*;

	logic [OPW-1:0]   a_q;
	logic [OPW-1:0]   b_q;
	logic [OPW-1:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [OPW+1:0]   t;
	logic [OPW+2:0]   d1;
	logic [OPW+2:0]   d2;
	logic [OPW-1:0]   r_next;

	// r < m and b < m keep t below 3m, so at most two subtractions are needed
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + (a_q[OPW-1] ? {2'b00, b_q} : '0);
		d1 = {1'b0, t} - {2'b00, m};
		d2 = {1'b0, t} - {1'b0, m, 1'b0};
		if (!d2[OPW+2]) begin
			r_next = d2[OPW-1:0];
		end else if (!d1[OPW+2]) begin
			r_next = d1[OPW-1:0];
		end else begin
			r_next = t[OPW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(OPW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (run_q) begin
			a_q <= {a_q[OPW-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign done = done_q;
	assign p    = r_q;

endmodule

### hdl/modular_exponentiation.sv
// Top level: configuration registers, square-and-multiply sequencer and output register.
// Each message gives message^exponent mod modulus (right-to-left square-and-multiply;
// a zero modulus acts as 2^32, a zero exponent gives 1). The work is serial: one
// message at a time, each modular product formed in a bit-serial multiplier
// that handles one multiplier bit per cycle. The message is first reduced (one product),
// then one step per exponent bit up to its highest set bit, the multiply and the square
// running side by side in two multipliers. A finished result sits in an output register,
// so the next message is taken while it waits to be transferred.
module modular_exponentiation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mexp_pkg::OPW-1:0]       cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mexp_pkg::OPW-1:0]       s_tdata,   // [31:0] message
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mexp_pkg::OPW-1:0]       m_tdata    // [31:0] power_mod
);
	import mexp_pkg::*;

	logic [OPW-1:0]      modulus_q;
	logic [OPW-1:0]      exponent_q;
	logic [OPW:0]        mod_ext;

	state_t              state_q;
	state_t              state_next;
	ctrl_t               ctrl;

	logic [OPW-1:0]      msg_q;
	logic [OPW-1:0]      acc_q;
	logic [OPW-1:0]      base_q;
	logic [EXP_BITS-1:0] e_q;
	logic [EXP_BITS-1:0] e_shr;

	logic [OPW-1:0]      acc_a;
	logic [OPW-1:0]      acc_b;
	logic                done_acc;
	logic                done_sq;
	logic [OPW-1:0]      p_acc;
	logic [OPW-1:0]      p_sq;

	logic                out_valid_q;
	logic [OPW-1:0]      out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RESET;
			exponent_q <= EXPONENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign mod_ext = {(modulus_q == '0), modulus_q};
	assign e_shr   = e_q >> 1;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_next = ST_RED_GO;
			end
			ST_RED_GO: state_next = ST_RED_WAIT;
			ST_RED_WAIT: begin
				if (done_acc) state_next = (e_q == '0) ? ST_DONE : ST_MUL_GO;
			end
			ST_MUL_GO: state_next = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (done_acc) state_next = (e_shr == '0) ? ST_DONE : ST_MUL_GO;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:   ctrl.in_ready  = 1'b1;
			ST_RED_GO: ctrl.start_acc = 1'b1;
			ST_MUL_GO: begin
				ctrl.start_acc = 1'b1;
				ctrl.start_sq  = 1'b1;
			end
			ST_DONE:   ctrl.out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// the reduction of the message reuses the multiply unit as message * 1
	assign acc_a = (state_q == ST_RED_GO) ? msg_q : acc_q;
	assign acc_b = (state_q == ST_RED_GO) ? OPW'(1) : base_q;

	mexp_mulmod u_mul_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.start_acc),
		.a      (acc_a),
		.b      (acc_b),
		.m      (mod_ext),
		.done   (done_acc),
		.p      (p_acc)
	);

	mexp_mulmod u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.start_sq),
		.a      (base_q),
		.b      (base_q),
		.m      (mod_ext),
		.done   (done_sq),
		.p      (p_sq)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && ctrl.in_ready) begin
			msg_q <= s_tdata;
			e_q   <= exponent_q[EXP_BITS-1:0];
			acc_q <= OPW'(1);
		end else if (state_q == ST_RED_WAIT && done_acc) begin
			base_q <= p_acc;
		end else if (state_q == ST_MUL_WAIT && done_acc) begin
			if (e_q[0]) acc_q <= p_acc;
			base_q <= p_sq;
			e_q    <= e_shr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) out_data_q <= acc_q;
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// both multipliers are started together and must finish together
	a_sq_with_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done_sq |-> done_acc && state_q == ST_MUL_WAIT)
		else $error("square unit finished out of step with multiply unit");

	// base stays reduced for the whole exponent scan
	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_WAIT) |-> ({1'b0, base_q} < mod_ext))
		else $error("base not reduced below modulus");

	// a result waiting in the output register is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || m_tready))
		else $error("output register loaded while holding an untaken result");

endmodule

### test/testbench.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module testbench;
	import mexp_pkg::*;

	localparam int WATCHDOG_LIMIT = 12000;
	localparam int HOLD_CYCLES    = 4000;
	localparam int END_SETTLE     = 1200;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 22;
	localparam int BURST_ITEMS    = 6;
	localparam int DIR_ROWS       = 19;

	typedef struct packed {
		logic [OPW-1:0] modulus;
		logic [OPW-1:0] exponent;
		logic [OPW-1:0] message;
		logic           known;
		logic [OPW-1:0] power;
	} drow_t;

	// modulus, exponent, message, result given, result
	localparam drow_t DIRECTED [0:DIR_ROWS-1] = '{
		'{MODULUS_RESET, EXPONENT_RESET, 32'h0000_0000, 1'b1, 32'd0},
		'{MODULUS_RESET, EXPONENT_RESET, 32'h0000_0001, 1'b1, 32'd1},
		'{MODULUS_RESET, EXPONENT_RESET, 32'hffff_ffff, 1'b0, 32'd0},
		'{MODULUS_RESET, EXPONENT_RESET, MODULUS_RESET, 1'b1, 32'd0},
		'{MODULUS_RESET, EXPONENT_RESET, 32'h0000_0002, 1'b0, 32'd0},
		'{MODULUS_RESET, 32'd0,          32'h1234_5678, 1'b1, 32'd1},
		'{32'd1,         32'd0,          32'h0000_0000, 1'b1, 32'd1},
		'{32'd1,         32'd5,          32'hffff_ffff, 1'b1, 32'd0},
		'{32'd1,         32'hffff_ffff,  32'h0000_0007, 1'b1, 32'd0},
		'{32'd0,         32'd2,          32'h0001_0000, 1'b1, 32'd0},
		'{32'd0,         32'hffff_ffff,  32'hffff_ffff, 1'b1, 32'hffff_ffff},
		'{32'd0,         32'd1,          32'hdead_beef, 1'b1, 32'hdead_beef},
		'{32'hffff_ffff, 32'hffff_ffff,  32'hffff_fffe, 1'b0, 32'd0},
		'{32'hffff_ffff, 32'd1,          32'hffff_ffff, 1'b1, 32'd0},
		'{32'hffff_fffb, 32'hffff_fffa,  32'h0000_0003, 1'b1, 32'd1},
		'{32'hffff_fffb, 32'h8000_0000,  32'hffff_ffff, 1'b0, 32'd0},
		'{32'd2,         32'd3,          32'hffff_ffff, 1'b1, 32'd1},
		'{32'h8000_0000, 32'd31,         32'h0000_0002, 1'b1, 32'd0},
		'{32'd1000,      32'd1,          32'hffff_ffff, 1'b1, 32'd295}
	};

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
	logic [OPW-1:0] cfg_data = '0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [OPW-1:0] s_tdata = '0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [OPW-1:0] m_tdata;

	logic [OPW-1:0] power_mod_q [$];
	logic [OPW-1:0] cur_modulus;
	logic [OPW-1:0] cur_exponent;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_ask;
	int rx_hold_left;
	int errors;
	int messages_sent;
	int results_checked;
	int settings_used;
	int stall_cycles;

	modular_exponentiation uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// zero modulus stands for 2^32
	function automatic logic [63:0] reduce_mod(input logic [63:0] v, input logic [OPW-1:0] m);
		if (m == '0)
			return {32'd0, v[31:0]};
		return v % {32'd0, m};
	endfunction

	function automatic logic [OPW-1:0] predict_power_mod(input logic [OPW-1:0] msg,
			input logic [OPW-1:0] m, input logic [OPW-1:0] ex);
		logic [63:0] base;
		logic [63:0] acc;
		logic [OPW-1:0] e;
		e = ex;
		base = reduce_mod({32'd0, msg}, m);
		acc = 64'd1;
		while (e != '0) begin
			if (e[0])
				acc = reduce_mod(acc * base, m);
			e = e >> 1;
			base = reduce_mod(base * base, m);
		end
		return acc[OPW-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [OPW-1:0] got,
			input logic [OPW-1:0] want);
		$display("%0t ns: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
		errors++;
	endtask

	// offer one message; the expectation is queued once the transfer happens
	task automatic send_message(input logic [OPW-1:0] msg, input logic [OPW-1:0] want);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= msg;
		do @(posedge clk); while (!s_tready);
		power_mod_q.push_back(want);
		messages_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (power_mod_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input logic [OPW-1:0] m, input logic [OPW-1:0] ex);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODULUS;
		cfg_data  <= m;
		@(posedge clk);
		cfg_index <= REG_EXPONENT;
		cfg_data  <= ex;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_modulus  = m;
		cur_exponent = ex;
		settings_used++;
	endtask

	// receiver: random back-pressure, or a long hold-off when asked
	initial begin
		rx_hold_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_ask > 0) begin
				rx_hold_left = rx_hold_ask;
				rx_hold_ask  = 0;
			end
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		logic [OPW-1:0] want;
		if (m_tvalid && m_tready) begin
			if (power_mod_q.size() == 0) begin
				report_mismatch("power_mod with nothing outstanding", m_tdata, '0);
			end else begin
				want = power_mod_q.pop_front();
				if (m_tdata !== want)
					report_mismatch("power_mod", m_tdata, want);
				results_checked++;
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
				$time, stall_cycles, power_mod_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [OPW-1:0] m;
		logic [OPW-1:0] ex;
		logic [OPW-1:0] msg;
		int len;
		errors = 0;
		messages_sent = 0;
		results_checked = 0;
		settings_used = 0;
		stall_cycles = 0;
		rx_hold_ask = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 79;
		cur_modulus  = MODULUS_RESET;
		cur_exponent = EXPONENT_RESET;
		do @(posedge clk); while (!arst_n);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].modulus != cur_modulus || DIRECTED[r].exponent != cur_exponent) begin
				drain_results();
				apply_config(DIRECTED[r].modulus, DIRECTED[r].exponent);
			end
			send_message(DIRECTED[r].message, DIRECTED[r].known ? DIRECTED[r].power :
				predict_power_mod(DIRECTED[r].message, cur_modulus, cur_exponent));
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			tx_idle_pct = (ph < 4) ? 10 : ((ph < 8) ? 79 : 0);
			rx_idle_pct = (ph < 4) ? 79 : ((ph < 8) ? 10 : 0);
			case ($urandom_range(0, 9))
				0: m = 32'd0;
				1: m = 32'd1;
				2: m = 32'hffff_ffff;
				3: m = $urandom_range(2, 1000);
				default: m = $urandom;
			endcase
			// mostly short exponents keep items quick; every fourth phase goes full width
			if (ph % 4 == 3) begin
				ex = $urandom;
			end else begin
				len = $urandom_range(0, 12);
				ex = (len == 0) ? '0 :
					((32'd1 << (len - 1)) | ($urandom & ((32'd1 << (len - 1)) - 1)));
			end
			drain_results();
			apply_config(m, ex);

			// output held off while messages keep coming: input must stall
			if (ph == 2) begin
				rx_hold_ask = HOLD_CYCLES;
				for (int i = 0; i < BURST_ITEMS; i++) begin
					msg = $urandom;
					send_message(msg, predict_power_mod(msg, cur_modulus, cur_exponent));
				end
				drain_results();
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 15))
					0: msg = 32'd0;
					1: msg = 32'hffff_ffff;
					2: msg = cur_modulus;
					3: msg = cur_modulus - 32'd1;
					default: msg = $urandom;
				endcase
				send_message(msg, predict_power_mod(msg, cur_modulus, cur_exponent));
			end
		end

		s_tvalid <= 1'b0;
		while (power_mod_q.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		$display("Covered %0d messages under %0d register settings, %0d results checked.",
			messages_sent, settings_used, results_checked);
		$display("Moduli 0, 1 and all-ones, exponents 0 and full width, long output hold-off.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
hdl/mexp_pkg.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation.sv
test/testbench.sv
